// ----- src/siu_pkg.sv -----
package siu_pkg;

  localparam int OFFSET_BITS_DEF = 48;
  localparam int FIFO_DEPTH_DEF  = 4;

  localparam logic [31:0] SPARSE_MAGIC   = 32'hED26FF3A;
  localparam logic [15:0] TYPE_RAW       = 16'hCAC1;
  localparam logic [15:0] TYPE_FILL      = 16'hCAC2;
  localparam logic [15:0] TYPE_DONT_CARE = 16'hCAC3;
  localparam logic [15:0] TYPE_CRC32     = 16'hCAC4;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_SIZE    = 2'd2;
  localparam logic [1:0] ERR_CHUNK   = 2'd3;

  typedef enum logic [1:0] {
    TAIL_NONE   = 2'd0,
    TAIL_FINISH = 2'd1,
    TAIL_ERROR  = 2'd2
  } tail_t;

  // one request into the queue: a run of writes, then an optional status result
  typedef struct packed {
    logic [2:0]      n_writes;
    logic [3:0][7:0] bytes;
    tail_t           tail;
    logic [1:0]      err;
  } cmd_t;

  localparam int CMD_BITS = $bits(cmd_t);

  function automatic logic [31:0] lane32(logic [31:0] d, logic [1:0] idx, logic [7:0] b);
    logic [31:0] r;
    r = d;
    r[8*idx +: 8] = b;
    return r;
  endfunction

  function automatic logic [15:0] lane16(logic [15:0] d, logic idx, logic [7:0] b);
    logic [15:0] r;
    r = d;
    r[8*idx +: 8] = b;
    return r;
  endfunction

endpackage

// ----- src/siu_cmd_fifo.sv -----
module siu_cmd_fifo #(
  parameter int WIDTH = siu_pkg::CMD_BITS,
  parameter int DEPTH = siu_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign head_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH-1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH-1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end
endmodule

// ----- src/siu_front.sv -----
module siu_front #(
  parameter int OFFSET_BITS = siu_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_image,
  input  logic [47:0]            part_bytes,
  output logic                   push,
  output siu_pkg::cmd_t          cmd,
  output logic [OFFSET_BITS-1:0] cmd_offset
);
  localparam int OB = OFFSET_BITS;
  localparam int CW = (OB > 48) ? OB : 48;
  localparam logic [OB-1:0] OMASK = '1;

  typedef enum logic [7:0] {
    PH_MAGIC   = 8'b0000_0001,
    PH_PLAIN   = 8'b0000_0010,
    PH_HDR     = 8'b0000_0100,
    PH_SKIPHDR = 8'b0000_1000,
    PH_CHUNK   = 8'b0001_0000,
    PH_RAW     = 8'b0010_0000,
    PH_SKIPCRC = 8'b0100_0000,
    PH_DONE    = 8'b1000_0000
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [4:0]    pos_r, pos_nxt;
  logic [31:0]   magic_r, magic_nxt;
  logic [15:0]   fhl_r, fhl_nxt;
  logic [31:0]   bl_r, bl_nxt, bt_r, bt_nxt, cl_r, cl_nxt;
  logic [15:0]   ct_r, ct_nxt;
  logic [31:0]   cb_r, cb_nxt;
  logic [63:0]   left_r, left_nxt;
  logic [OB-1:0] off_r, off_nxt;
  logic [63:0]   prod_r;

  logic [CW-1:0] lim;
  logic          off_ok;
  logic [31:0]   mag_new;
  logic [2:0]    flush_n;
  logic          do_flush;
  logic          nc_req;
  logic [31:0]   nc_cnt;
  logic [OB-1:0] room;

  // shared multiplier: header total size, then chunk length
  always_ff @(posedge clk) begin
    prod_r <= bl_r * ((phase_r == PH_HDR) ? bt_r : cb_r);
  end

  always_comb begin
    lim = (CW'(part_bytes) < CW'(OMASK)) ? CW'(part_bytes) : CW'(OMASK);
    off_ok = CW'(off_r) < lim;
    mag_new = siu_pkg::lane32(magic_r, pos_r[1:0], data_byte);
    room = OMASK - off_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    magic_nxt = magic_r;
    fhl_nxt   = fhl_r;
    bl_nxt    = bl_r;
    bt_nxt    = bt_r;
    cl_nxt    = cl_r;
    ct_nxt    = ct_r;
    cb_nxt    = cb_r;
    left_nxt  = left_r;
    off_nxt   = off_r;
    cmd          = '0;
    cmd.tail     = siu_pkg::TAIL_NONE;
    cmd_offset   = off_r;
    do_flush  = 1'b0;
    flush_n   = 3'd0;
    nc_req    = 1'b0;
    nc_cnt    = cl_r;

    unique case (phase_r)
      PH_MAGIC: begin
        magic_nxt = mag_new;
        pos_nxt   = pos_r + 1'b1;
        if (pos_r >= 5'd3) begin
          if (mag_new == siu_pkg::SPARSE_MAGIC) begin
            phase_nxt = PH_HDR;
            magic_nxt = '0;
          end else begin
            do_flush = 1'b1;
            flush_n  = 3'd4;
          end
        end else if (end_of_image) begin
          do_flush = 1'b1;
          flush_n  = 3'(pos_r) + 3'd1;
        end
      end
      PH_PLAIN, PH_RAW: begin
        if (off_ok) begin
          cmd.n_writes = 3'd1;
          cmd.bytes[0] = data_byte;
          off_nxt      = off_r + 1'b1;
          if (phase_r == PH_RAW) begin
            if (left_r <= 64'd1) begin
              nc_req = 1'b1;
              nc_cnt = cl_r - 1'b1;
            end else begin
              left_nxt = left_r - 1'b1;
            end
          end
        end else begin
          cmd.tail  = siu_pkg::TAIL_ERROR;
          cmd.err   = siu_pkg::ERR_SIZE;
          phase_nxt = PH_DONE;
        end
      end
      PH_HDR: begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == 5'd4 || pos_r == 5'd5) begin
          magic_nxt = siu_pkg::lane32(magic_r, pos_r[1:0], data_byte);
          if (pos_r == 5'd5 && magic_nxt != 32'd1) begin
            cmd.tail  = siu_pkg::TAIL_ERROR;
            cmd.err   = siu_pkg::ERR_VERSION;
            phase_nxt = PH_DONE;
          end
        end else if (pos_r == 5'd8 || pos_r == 5'd9) begin
          fhl_nxt = siu_pkg::lane16(fhl_r, pos_r[0], data_byte);
        end else if (pos_r >= 5'd12 && pos_r <= 5'd15) begin
          bl_nxt = siu_pkg::lane32(bl_r, pos_r[1:0], data_byte);
        end else if (pos_r >= 5'd16 && pos_r <= 5'd19) begin
          bt_nxt = siu_pkg::lane32(bt_r, pos_r[1:0], data_byte);
        end else if (pos_r >= 5'd20 && pos_r <= 5'd23) begin
          cl_nxt = siu_pkg::lane32(cl_r, pos_r[1:0], data_byte);
          if (pos_r == 5'd23 && prod_r > 64'(part_bytes)) begin
            cmd.tail  = siu_pkg::TAIL_ERROR;
            cmd.err   = siu_pkg::ERR_SIZE;
            phase_nxt = PH_DONE;
          end
        end
        if (pos_r >= 5'd27) begin
          if (fhl_r > 16'd28) begin
            left_nxt  = 64'(fhl_r - 16'd28);
            phase_nxt = PH_SKIPHDR;
          end else begin
            nc_req = 1'b1;
          end
        end
      end
      PH_SKIPHDR, PH_SKIPCRC: begin
        if (left_r <= 64'd1) begin
          nc_req = 1'b1;
          if (phase_r == PH_SKIPCRC) begin
            nc_cnt = cl_r - 1'b1;
          end
        end else begin
          left_nxt = left_r - 1'b1;
        end
      end
      PH_CHUNK: begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r <= 5'd1) begin
          ct_nxt = siu_pkg::lane16(ct_r, pos_r[0], data_byte);
        end else if (pos_r >= 5'd4 && pos_r <= 5'd7) begin
          cb_nxt = siu_pkg::lane32(cb_r, pos_r[1:0], data_byte);
        end
        if (pos_r >= 5'd11) begin
          if (ct_r == siu_pkg::TYPE_RAW) begin
            if (prod_r == 64'd0) begin
              nc_req = 1'b1;
              nc_cnt = cl_r - 1'b1;
            end else begin
              left_nxt  = prod_r;
              phase_nxt = PH_RAW;
            end
          end else if (ct_r == siu_pkg::TYPE_DONT_CARE) begin
            off_nxt = (prod_r > 64'(room)) ? OMASK : off_r + OB'(prod_r);
            nc_req  = 1'b1;
            nc_cnt  = cl_r - 1'b1;
          end else if (ct_r == siu_pkg::TYPE_CRC32) begin
            left_nxt  = 64'd4;
            phase_nxt = PH_SKIPCRC;
          end else begin
            cmd.tail  = siu_pkg::TAIL_ERROR;
            cmd.err   = siu_pkg::ERR_CHUNK;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // spill of held-back bytes at offsets from zero, with a size error if the partition is too small
    if (do_flush) begin
      phase_nxt    = PH_PLAIN;
      cmd_offset   = '0;
      cmd.bytes    = mag_new;
      if (lim < CW'(flush_n)) begin
        cmd.n_writes = lim[2:0];
        cmd.tail     = siu_pkg::TAIL_ERROR;
        cmd.err      = siu_pkg::ERR_SIZE;
        phase_nxt    = PH_DONE;
      end else begin
        cmd.n_writes = flush_n;
      end
      off_nxt = OB'(cmd.n_writes);
    end

    if (nc_req) begin
      cl_nxt = nc_cnt;
      if (nc_cnt == 32'd0) begin
        cmd.tail  = siu_pkg::TAIL_FINISH;
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_CHUNK;
        pos_nxt   = '0;
        ct_nxt    = '0;
        cb_nxt    = '0;
      end
    end

    if (end_of_image) begin
      if (phase_nxt != PH_DONE) begin
        cmd.tail = siu_pkg::TAIL_FINISH;
      end
      phase_nxt = PH_MAGIC;
      pos_nxt   = '0;
      magic_nxt = '0;
      fhl_nxt   = '0;
      bl_nxt    = '0;
      bt_nxt    = '0;
      cl_nxt    = '0;
      ct_nxt    = '0;
      cb_nxt    = '0;
      left_nxt  = '0;
      off_nxt   = '0;
    end

    push = accept && (cmd.n_writes != 3'd0 || cmd.tail != siu_pkg::TAIL_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      pos_r   <= '0;
      magic_r <= '0;
      fhl_r   <= '0;
      bl_r    <= '0;
      bt_r    <= '0;
      cl_r    <= '0;
      ct_r    <= '0;
      cb_r    <= '0;
      left_r  <= '0;
      off_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      magic_r <= magic_nxt;
      fhl_r   <= fhl_nxt;
      bl_r    <= bl_nxt;
      bt_r    <= bt_nxt;
      cl_r    <= cl_nxt;
      ct_r    <= ct_nxt;
      cb_r    <= cb_nxt;
      left_r  <= left_nxt;
      off_r   <= off_nxt;
    end
  end
endmodule

// ----- src/siu_back.sv -----
module siu_back #(
  parameter int OFFSET_BITS = siu_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  siu_pkg::cmd_t          q_cmd,
  input  logic [OFFSET_BITS-1:0] q_offset,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_kind,
  output logic [47:0]            out_write_offset,
  output logic [7:0]             out_write_byte,
  output logic [1:0]             out_error_code,
  output logic                   out_last_result
);
  logic [2:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  logic [1:0]  kind_r, kind_nxt, err_r, err_nxt;
  logic [47:0] off_r, off_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  total;
  logic        load;

  always_comb begin
    total = q_cmd.n_writes + ((q_cmd.tail != siu_pkg::TAIL_NONE) ? 3'd1 : 3'd0);
    load  = !q_empty && (!vld_r || out_ready);
    q_pop = load && (idx_r == total - 3'd1);
    idx_nxt  = idx_r;
    vld_nxt  = vld_r && !out_ready;
    kind_nxt = kind_r;
    err_nxt  = err_r;
    off_nxt  = off_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      idx_nxt  = q_pop ? 3'd0 : idx_r + 3'd1;
      last_nxt = q_pop;
      if (idx_r < q_cmd.n_writes) begin
        kind_nxt = siu_pkg::KIND_WRITE;
        err_nxt  = siu_pkg::ERR_NONE;
        off_nxt  = 48'(q_offset + OFFSET_BITS'(idx_r));
        byte_nxt = q_cmd.bytes[idx_r[1:0]];
      end else begin
        kind_nxt = (q_cmd.tail == siu_pkg::TAIL_ERROR) ? siu_pkg::KIND_ERROR
                                                        : siu_pkg::KIND_FINISH;
        err_nxt  = (q_cmd.tail == siu_pkg::TAIL_ERROR) ? q_cmd.err : siu_pkg::ERR_NONE;
        off_nxt  = '0;
        byte_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    err_r  <= err_nxt;
    off_r  <= off_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = vld_r;
  assign out_kind         = kind_r;
  assign out_write_offset = off_r;
  assign out_write_byte   = byte_r;
  assign out_error_code   = err_r;
  assign out_last_result  = last_r;
endmodule

// ----- src/sparse_image_unpacker.sv -----
// Sparse image unpacker: turns an image byte stream into partition writes.
// Input channel in_*: one image byte a request, in_end_of_image on the last.
// Output channel out_*: one result a request (write, finished or error);
//   out_last_result marks the final result caused by one input byte.
// Config channel cfg_*: partition size in bytes, always ready; write only
//   while the block is idle. Resets to all ones.
// Throughput: one input byte a cycle while each byte gives at most one
//   result and out_ready is high; the held-back magic bytes of a plain
//   image come out as up to five results, one a cycle while out_ready is
//   high, from the result sequencer. A byte is decoded and queued at the
//   edge that accepts it; the sequencer then loads the output register
//   from the queue head.
// A stalled receiver holds the output register; the command queue
//   (FIFO_DEPTH entries) absorbs bytes until full, then in_ready drops.
// Reset (synchronous, rst_n low) empties the queue and output, and arms
//   magic detection for a new image at offset zero.
module sparse_image_unpacker #(
  parameter int OFFSET_BITS = siu_pkg::OFFSET_BITS_DEF,
  parameter int FIFO_DEPTH  = siu_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [47:0] out_write_offset,
  output logic [7:0]  out_write_byte,
  output logic [1:0]  out_error_code,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_partition_bytes
);
  localparam int QW = siu_pkg::CMD_BITS + OFFSET_BITS;

  logic [47:0]            part_r;
  logic                   accept, push, pop, q_empty, q_full;
  siu_pkg::cmd_t          f_cmd, q_cmd;
  logic [OFFSET_BITS-1:0] f_off, q_off;
  logic [QW-1:0]          q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '1;
    end else if (cfg_valid) begin
      part_r <= cfg_partition_bytes;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front: parses the byte stream, tracks the running offset
  siu_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .end_of_image (in_end_of_image),
    .part_bytes   (part_r),
    .push         (push),
    .cmd          (f_cmd),
    .cmd_offset   (f_off)
  );

  siu_cmd_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cmd, f_off}),
    .pop       (pop),
    .head_data (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign q_cmd = siu_pkg::cmd_t'(q_head[QW-1:OFFSET_BITS]);
  assign q_off = q_head[OFFSET_BITS-1:0];

  // back: expands each queued request into results
  siu_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (q_cmd),
    .q_offset         (q_off),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_write_offset (out_write_offset),
    .out_write_byte   (out_write_byte),
    .out_error_code   (out_error_code),
    .out_last_result  (out_last_result)
  );
endmodule
